// ===== design/ske_pkg.sv =====
package ske_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_REVERSE_ORDER = 2'd0;
	localparam logic [1:0] REG_KEEP_MODE     = 2'd1;
	localparam logic [1:0] REG_FOLD_CASE     = 2'd2;

	// Keep filter modes; the unused code keeps all bytes
	localparam logic [1:0] KEEP_ALL       = 2'd0;
	localparam logic [1:0] KEEP_DICT      = 2'd1;
	localparam logic [1:0] KEEP_PRINTABLE = 2'd2;

	// Escape lead bytes and terminator
	localparam logic [7:0] ESC_LOW    = 8'h01;
	localparam logic [7:0] ESC_HIGH   = 8'hFF;
	localparam logic [7:0] TERM_BYTE  = 8'h00;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// Most result beats that one input item can cause
	localparam int RUN_DEPTH = 3;
	localparam int RUN_CNT_W = $clog2(RUN_DEPTH + 1);

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       field_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] key_byte;
		logic       is_terminator;
		logic       last_of_run;
	} out_beat_t;

	typedef struct packed {
		logic       reverse_order;
		logic [1:0] keep_mode;
		logic       fold_case;
	} cfg_t;

	typedef struct packed {
		out_beat_t [RUN_DEPTH-1:0] beats;
		logic [RUN_CNT_W-1:0]      count;
	} run_t;

endpackage

// ===== design/sort_key_text_encoder.sv =====
// Sort key text encoder: turns the bytes of a text key field into a key whose
// byte order gives the collation order. Each input beat is filtered, optionally
// case folded, escaped (0/1 as 0x01 then value+1, 254/255 as 0xFF then
// value-1), complemented in reverse order, and followed by a terminator when it
// ends the field. An input beat yields 0 to 3 result beats, which share the single
// output port: with one result per item and no output stall the block takes one
// item every cycle; an escaped byte or a terminator holds the input back, since a
// new item is taken only as the last beat of the run moves to the output register.
// The first result beat of an item passes through the run buffer and then the
// output register. Configuration is written by index through wr_en, wr_index and
// wr_data and should change only while the block is idle.
module sort_key_text_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ske_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output ske_pkg::out_beat_t out_data,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [1:0]         wr_data
);
	import ske_pkg::*;

	cfg_t cfg;
	run_t run;
	logic in_ready;

	// Configuration registers
	ske_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// Encode one input beat into its run of result beats
	ske_encode u_encode (
		.in_beat (in_data),
		.cfg     (cfg),
		.run     (run)
	);

	// Run buffer and output register
	ske_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.run_in    (run),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign in_stall = !in_ready;

endmodule

// ===== design/ske_cfg_regs.sv =====
module ske_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [1:0]       wr_index,
	input  logic [1:0]       wr_data,
	output ske_pkg::cfg_t    cfg
);
	import ske_pkg::*;

	cfg_t cfg_q;

	// Take register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_REVERSE_ORDER: cfg_q.reverse_order <= wr_data[0];
				REG_KEEP_MODE:     cfg_q.keep_mode     <= wr_data;
				REG_FOLD_CASE:     cfg_q.fold_case     <= wr_data[0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ske_encode.sv =====
module ske_encode (
	input  ske_pkg::in_beat_t in_beat,
	input  ske_pkg::cfg_t     cfg,
	output ske_pkg::run_t     run
);
	import ske_pkg::*;

	logic       kept;
	logic       alnum;
	logic [7:0] c;
	logic [7:0] flip;
	logic [RUN_CNT_W-1:0] n;

	// Keep filter
	always_comb begin
		alnum = (in_beat.text_byte inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
		case (cfg.keep_mode)
			KEEP_DICT:      kept = alnum || (in_beat.text_byte inside {8'h20, 8'h09});
			KEEP_PRINTABLE: kept = (in_beat.text_byte inside {[8'h20:8'h7E]});
			default:        kept = 1'b1;
		endcase
	end

	// Fold case, escape, complement and append terminator
	always_comb begin
		flip = {8{cfg.reverse_order}};
		c    = in_beat.text_byte;
		if (cfg.fold_case && (c inside {[8'h61:8'h7A]})) begin
			c = c - CASE_DELTA;
		end
		run = '0;
		n   = '0;
		if (in_beat.byte_present && kept) begin
			if (c inside {8'h00, 8'h01}) begin
				run.beats[n].key_byte = ESC_LOW ^ flip;
				n = n + 1'b1;
				c = c + 8'd1;
			end else if (c inside {8'hFE, 8'hFF}) begin
				run.beats[n].key_byte = ESC_HIGH ^ flip;
				n = n + 1'b1;
				c = c - 8'd1;
			end
			run.beats[n].key_byte = c ^ flip;
			n = n + 1'b1;
		end
		if (in_beat.field_end) begin
			run.beats[n].key_byte      = TERM_BYTE ^ flip;
			run.beats[n].is_terminator = 1'b1;
			n = n + 1'b1;
		end
		if (n != '0) begin
			run.beats[n - 1'b1].last_of_run = 1'b1;
		end
		run.count = n;
	end

endmodule

// ===== design/ske_out_queue.sv =====
module ske_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ske_pkg::run_t      run_in,
	output logic               out_valid,
	input  logic               out_stall,
	output ske_pkg::out_beat_t out_data
);
	import ske_pkg::*;

	out_beat_t [RUN_DEPTH-1:0] run_beats_q;
	logic [RUN_CNT_W-1:0]      run_cnt_q;
	out_beat_t                 out_q;
	logic                      out_valid_q;
	logic                      out_load;
	logic                      in_acc;

	// Move the head of the run into the output register when it is free
	assign out_load = (run_cnt_q != '0) && (!out_valid_q || !out_stall);
	assign in_ready = (run_cnt_q == '0) ||
		((run_cnt_q == RUN_CNT_W'(1)) && out_load);
	assign in_acc   = in_valid && in_ready;

	// Run buffer: load a fresh run or advance by one beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= '0;
		end else if (in_acc) begin
			run_cnt_q <= run_in.count;
		end else if (out_load) begin
			run_cnt_q <= run_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_beats_q <= run_in.beats;
		end else if (out_load) begin
			for (int i = 0; i < RUN_DEPTH - 1; i++) begin
				run_beats_q[i] <= run_beats_q[i+1];
			end
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= run_beats_q[0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ske_pkg::*;

	// Unused keep selector, behaves like keep all
	localparam logic [1:0] KEEP_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT = 2000;
	localparam logic [7:0] CH_TAB = 8'h09;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_data;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [1:0] wr_data = '0;

	// Mirror of the configuration registers
	logic rev_order = 1'b0;
	logic [1:0] keep_sel = KEEP_ALL;
	logic fold_upper = 1'b0;

	out_beat_t expected_key_q[$];
	int send_idle_pct = 37;
	int recv_idle_pct = 47;
	int fail_count = 0;
	int quiet_cycles = 0;

	sort_key_text_encoder i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// Keep filter for the current keep selector
	function automatic logic byte_kept(input logic [7:0] c);
		logic alnum;
		alnum = (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
		case (keep_sel)
			KEEP_DICT: return alnum || c == " " || c == CH_TAB;
			KEEP_PRINTABLE: return c >= 8'h20 && c <= 8'h7E;
			default: return 1'b1;
		endcase
	endfunction

	// Work out the key beats of one text beat and queue them
	function automatic void predict_key_beats(input in_beat_t b);
		out_beat_t run[$];
		out_beat_t beat;
		logic [7:0] c;
		logic [7:0] flip;
		c = b.text_byte;
		flip = rev_order ? 8'hFF : 8'h00;
		if (b.byte_present && byte_kept(c)) begin
			if (fold_upper && c >= "a" && c <= "z") begin
				c = c - 8'h20;
			end
			if (c <= 8'd1) begin
				beat = '{key_byte: 8'h01 ^ flip, is_terminator: 1'b0, last_of_run: 1'b0};
				run.push_back(beat);
				c = c + 8'd1;
			end else if (c >= 8'd254) begin
				beat = '{key_byte: 8'hFF ^ flip, is_terminator: 1'b0, last_of_run: 1'b0};
				run.push_back(beat);
				c = c - 8'd1;
			end
			beat = '{key_byte: c ^ flip, is_terminator: 1'b0, last_of_run: 1'b0};
			run.push_back(beat);
		end
		if (b.field_end) begin
			beat = '{key_byte: flip, is_terminator: 1'b1, last_of_run: 1'b0};
			run.push_back(beat);
		end
		if (run.size() > 0) begin
			run[run.size() - 1].last_of_run = 1'b1;
		end
		foreach (run[i]) begin
			expected_key_q.push_back(run[i]);
		end
	endfunction

	// Offer one text beat, idling at random first, and hold it until taken
	task automatic send_text_beat(input logic [7:0] c, input logic present, input logic fend);
		in_beat_t b;
		b = '{text_byte: c, byte_present: present, field_end: fend};
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		predict_key_beats(b);
	endtask

	// Drop valid and wait until every key beat has come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_key_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			REG_REVERSE_ORDER: rev_order = val[0];
			REG_KEEP_MODE: keep_sel = val;
			REG_FOLD_CASE: fold_upper = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic rev, input logic [1:0] keep, input logic fold);
		wait_idle();
		write_reg(REG_REVERSE_ORDER, {1'b0, rev});
		write_reg(REG_KEEP_MODE, keep);
		write_reg(REG_FOLD_CASE, {1'b0, fold});
		wr_en <= 1'b0;
	endtask

	// Mostly text, with escape values and arbitrary bytes mixed in
	function automatic logic [7:0] pick_text_byte();
		case ($urandom_range(9))
			0, 1, 2: return 8'($urandom_range(8'h61, 8'h7A));
			3: return 8'($urandom_range(8'h41, 8'h5A));
			4: return 8'($urandom_range(8'h30, 8'h39));
			5: return $urandom_range(1) ? " " : CH_TAB;
			6: return $urandom_range(1) ? 8'($urandom_range(1)) : 8'($urandom_range(254, 255));
			7: return 8'($urandom_range(8'h20, 8'h7E));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Whole fields with random content, plus some noise and empty beats
	task automatic send_random_fields(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(4) == 0) begin
				send_text_beat(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end else begin
				len = $urandom_range(6);
				if (len == 0) begin
					send_text_beat(8'($urandom_range(255)), 1'b0, 1'b1);
					sent++;
				end
				for (int i = 0; i < len; i++) begin
					send_text_beat(pick_text_byte(), 1'b1, i == len - 1);
					sent++;
					if ($urandom_range(7) == 0) begin
						send_text_beat(8'($urandom_range(255)), 1'b0, 1'b0);
						sent++;
					end
				end
			end
			// hold the sender now and then until the output has drained
			if ($urandom_range(39) == 0) begin
				in_valid <= 1'b0;
				while (expected_key_q.size() != 0) @(posedge clk);
			end
		end
	endtask

	task automatic test_escapes();
		set_config(1'b0, KEEP_ALL, 1'b0);
		send_text_beat(8'h00, 1'b1, 1'b0);
		send_text_beat(8'h01, 1'b1, 1'b0);
		send_text_beat(8'hFE, 1'b1, 1'b0);
		send_text_beat(8'hFF, 1'b1, 1'b1);
		send_text_beat(8'h02, 1'b1, 1'b0);
		send_text_beat(8'hFD, 1'b1, 1'b1);
		// empty beat, then a bare end mark
		send_text_beat(8'h41, 1'b0, 1'b0);
		send_text_beat(8'hFF, 1'b0, 1'b1);
	endtask

	task automatic test_keep_modes();
		set_config(1'b0, KEEP_DICT, 1'b0);
		send_text_beat(8'h21, 1'b1, 1'b0);
		send_text_beat("a", 1'b1, 1'b0);
		send_text_beat(CH_TAB, 1'b1, 1'b0);
		send_text_beat("Z", 1'b1, 1'b0);
		send_text_beat("7", 1'b1, 1'b1);
		set_config(1'b0, KEEP_PRINTABLE, 1'b0);
		send_text_beat(8'h1F, 1'b1, 1'b0);
		send_text_beat(8'h20, 1'b1, 1'b0);
		send_text_beat(8'h7E, 1'b1, 1'b0);
		send_text_beat(8'h7F, 1'b1, 1'b1);
		set_config(1'b0, KEEP_SPARE, 1'b0);
		send_text_beat(8'h00, 1'b1, 1'b0);
		send_text_beat(8'h80, 1'b1, 1'b1);
	endtask

	task automatic test_fold_reverse();
		set_config(1'b1, KEEP_ALL, 1'b1);
		send_text_beat("a", 1'b1, 1'b0);
		send_text_beat("z", 1'b1, 1'b0);
		send_text_beat(8'h7B, 1'b1, 1'b0);
		send_text_beat(8'h60, 1'b1, 1'b0);
		send_text_beat(8'h00, 1'b1, 1'b0);
		send_text_beat(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_random();
		send_idle_pct = 37;
		recv_idle_pct = 47;
		set_config(1'b0, KEEP_ALL, 1'b0);
		send_random_fields(31);
		set_config(1'b1, KEEP_SPARE, 1'b1);
		send_random_fields(31);
		send_idle_pct = 47;
		recv_idle_pct = 37;
		set_config(1'b0, KEEP_DICT, 1'b1);
		send_random_fields(31);
		set_config(1'b1, KEEP_PRINTABLE, 1'b0);
		send_random_fields(31);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(1'b1, KEEP_ALL, 1'b0);
		send_random_fields(31);
		set_config(1'($urandom_range(1)), 2'($urandom_range(3)), 1'($urandom_range(1)));
		send_random_fields(31);
	endtask

	// Receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Check each key beat against the oldest expectation
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_key_q.size() == 0) begin
				report_mismatch("unexpected key beat", out_data, 0);
			end else begin
				want = expected_key_q.pop_front();
				if (out_data.key_byte !== want.key_byte) begin
					report_mismatch("key_byte", out_data.key_byte, want.key_byte);
				end
				if (out_data.is_terminator !== want.is_terminator) begin
					report_mismatch("is_terminator", out_data.is_terminator,
						want.is_terminator);
				end
				if (out_data.last_of_run !== want.last_of_run) begin
					report_mismatch("last_of_run", out_data.last_of_run, want.last_of_run);
				end
			end
		end
	end

	// Watchdog on cycles without any beat taken
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_escapes();
		test_keep_modes();
		test_fold_reverse();
		test_random();
		wait_idle();
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/ske_pkg.sv
design/ske_cfg_regs.sv
design/ske_encode.sv
design/ske_out_queue.sv
design/sort_key_text_encoder.sv
tb/testbench.sv
